// ===== hw/rtl/crv_pkg.sv =====
// Shared constants and types for the calibration record validator.
`default_nettype none
package crv_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned ADDR_W = 3;

    localparam logic [DATA_W-1:0] CHK_SEED    = 32'h9E37_79B9;
    localparam logic [DATA_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] MAG_MASK    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] LIM_ROT     = 32'h4334_0000;
    localparam logic [DATA_W-1:0] LIM_GYRO    = 32'h41A0_0000;
    localparam logic [DATA_W-1:0] LIM_ACCEL   = 32'h3F80_0000;

    localparam logic [POS_W-1:0] POS_MAGIC   = 4'd0;
    localparam logic [POS_W-1:0] POS_VERSION = 4'd1;
    localparam logic [POS_W-1:0] POS_ROT_LO  = 4'd2;
    localparam logic [POS_W-1:0] POS_ROT_HI  = 4'd4;
    localparam logic [POS_W-1:0] POS_GYRO_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_ACC_HI  = 4'd10;
    localparam logic [POS_W-1:0] POS_LAST    = 4'd11;

    localparam logic [DATA_W-1:0] MAGIC_RESET   = 32'd0;
    localparam logic [DATA_W-1:0] VERSION_RESET = 32'd1;

    typedef enum logic [1:0] {
        ST_NOT_CAL = 2'd0,
        ST_VALID   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic {
        REG_MAGIC   = 1'b0,
        REG_VERSION = 1'b1
    } reg_idx_t;

    function automatic logic field_fails(logic [POS_W-1:0] pos, logic [DATA_W-1:0] w);
        logic [DATA_W-1:0] mag;
        logic              fail;
        mag  = w & MAG_MASK;
        fail = 1'b0;
        if (pos >= POS_ROT_LO && pos <= POS_ROT_HI) begin
            fail = mag > LIM_ROT;
        end else if (pos > POS_ROT_HI && pos <= POS_GYRO_HI) begin
            fail = mag > LIM_GYRO;
        end else if (pos > POS_GYRO_HI && pos <= POS_ACC_HI) begin
            fail = mag > LIM_ACCEL;
        end
        return fail;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/calibration_record_validator.sv =====
// Calibration record validator: checks a 12-word record and reports its status.
// The status appears in m_status in the cycle after word eleven is accepted.
// Throughput: one word per cycle; while a status waits in the output register
// with m_ready low, input is held off until the status is taken.
// Reset: synchronous, active low; clears record state, output valid and the
// registers to magic 0 and version 1.
`default_nettype none
module calibration_record_validator
    import crv_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [DATA_W-1:0]  s_word,
    input  wire                s_first,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [1:0]         m_status,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [ADDR_W-1:0]  paddr,
    input  wire  [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [DATA_W-1:0] magic_reg, version_reg;
    logic [POS_W-1:0]  pos_reg, pos_next, pos_cur;
    logic [DATA_W-1:0] sum_reg, sum_next, sum_cur;
    logic              erased_reg, erased_next, erased_cur;
    logic              lead_zero_reg, lead_zero_next, lead_zero_cur;
    logic              fault_reg, fault_next, fault_cur;
    logic              m_valid_reg;
    status_t           status_reg, status_next;
    logic              accept, last, wr_en;
    reg_idx_t          reg_sel;

    assign pready   = 1'b1;
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        unique case (reg_sel)
            REG_MAGIC:   prdata = magic_reg;
            REG_VERSION: prdata = version_reg;
            default:     prdata = magic_reg;
        endcase
    end

    always_comb begin
        pos_cur       = s_first ? POS_MAGIC : pos_reg;
        if (pos_cur > POS_LAST) begin
            pos_cur = POS_MAGIC;
        end
        sum_cur       = s_first ? CHK_SEED : sum_reg;
        erased_cur    = s_first ? 1'b1 : erased_reg;
        lead_zero_cur = s_first ? 1'b0 : lead_zero_reg;
        fault_cur     = s_first ? 1'b0 : fault_reg;

        erased_next    = erased_cur && (s_word == ERASED_WORD);
        lead_zero_next = lead_zero_cur;
        fault_next     = fault_cur;
        if (pos_cur == POS_MAGIC) begin
            lead_zero_next = (s_word == '0);
            fault_next     = fault_cur || (s_word != magic_reg);
        end else if (pos_cur == POS_VERSION) begin
            fault_next = fault_cur || (s_word != version_reg);
        end else if (pos_cur < POS_LAST) begin
            fault_next = fault_cur || field_fails(pos_cur, s_word);
        end

        last     = (pos_cur == POS_LAST);
        sum_next = (sum_cur << 5) - sum_cur + s_word;
        pos_next = pos_cur + POS_W'(1);

        priority if (erased_next || lead_zero_next) begin
            status_next = ST_NOT_CAL;
        end else if (fault_next || s_word != sum_cur) begin
            status_next = ST_INVALID;
        end else begin
            status_next = ST_VALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg     <= MAGIC_RESET;
            version_reg   <= VERSION_RESET;
            pos_reg       <= POS_MAGIC;
            sum_reg       <= CHK_SEED;
            erased_reg    <= 1'b1;
            lead_zero_reg <= 1'b0;
            fault_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            status_reg    <= ST_NOT_CAL;
        end else begin
            if (wr_en) begin
                unique case (reg_sel)
                    REG_MAGIC:   magic_reg   <= pwdata;
                    REG_VERSION: version_reg <= pwdata;
                    default:     magic_reg   <= magic_reg;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (last) begin
                    pos_reg       <= POS_MAGIC;
                    sum_reg       <= CHK_SEED;
                    erased_reg    <= 1'b1;
                    lead_zero_reg <= 1'b0;
                    fault_reg     <= 1'b0;
                    m_valid_reg   <= 1'b1;
                    status_reg    <= status_next;
                end else begin
                    pos_reg       <= pos_next;
                    sum_reg       <= sum_next;
                    erased_reg    <= erased_next;
                    lead_zero_reg <= lead_zero_next;
                    fault_reg     <= fault_next;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/crv_checker.sv =====
// Port-level checks for the calibration record validator, bound to the top level.
`default_nettype none
module crv_checker
    import crv_pkg::*;
(
    input wire              aclk,
    input wire              aresetn,
    input wire              s_ready,
    input wire              m_valid,
    input wire              m_ready,
    input wire [1:0]        m_status
);

    // hold a stalled status
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("status changed while stalled");

    a_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_NOT_CAL || m_status == ST_VALID
                     || m_status == ST_INVALID))
        else $error("status code out of range");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked while output free");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("status dropped before it was taken");

endmodule

bind calibration_record_validator crv_checker u_crv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the calibration record validator: directed and random records.
module testbench;
    import crv_pkg::*;

    localparam logic [DATA_W-1:0] CHK_MULT = 32'd31;
    localparam int RECORD_LEN      = 12;
    localparam int RANDOM_WORDS    = 1880;
    localparam int PHASES          = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef logic [RECORD_LEN-1:0][DATA_W-1:0] record_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_e;
    typedef enum {
        REC_GOOD, REC_BAD_FIELD, REC_BAD_MAGIC, REC_BAD_VERSION,
        REC_BAD_SUM, REC_LEAD_ZERO, REC_ERASED, REC_TRUNCATED
    } rec_kind_e;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic [DATA_W-1:0]  s_word  = '0;
    logic               s_first = 1'b0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire  [1:0]         m_status;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [ADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    wire  [DATA_W-1:0]  prdata;
    wire                pready;

    logic [DATA_W-1:0]  cfg_magic     = MAGIC_RESET;
    logic [DATA_W-1:0]  cfg_version   = VERSION_RESET;
    logic [POS_W-1:0]   rec_pos       = POS_MAGIC;
    logic [DATA_W-1:0]  rec_sum       = CHK_SEED;
    logic               rec_erased    = 1'b1;
    logic               rec_lead_zero = 1'b0;
    logic               rec_fault     = 1'b0;
    status_t            expected_status[$];
    status_t            want_status;

    int                 words_sent    = 0;
    int                 n_configs     = 0;
    int                 reg_errors    = 0;
    int                 result_errors = 0;
    int                 status_seen[3] = '{0, 0, 0};
    int                 tx_gap_max    = 0;
    int                 burst_left    = 0;
    rx_mode_e           rx_mode       = RX_ALWAYS;
    logic               hold_armed    = 1'b0;
    logic               hold_taken    = 1'b0;
    int                 hold_left     = 0;
    logic [15:0]        rx_pattern    = 16'b1011_0011_1000_1101;

    calibration_record_validator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .s_first  (s_first),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [DATA_W-1:0] field_limit(input logic [POS_W-1:0] pos);
        if (pos >= POS_ROT_LO && pos <= POS_ROT_HI) return LIM_ROT;
        if (pos > POS_ROT_HI && pos <= POS_GYRO_HI) return LIM_GYRO;
        if (pos > POS_GYRO_HI && pos <= POS_ACC_HI) return LIM_ACCEL;
        return MAG_MASK;
    endfunction

    function automatic logic [DATA_W-1:0] field_value(input logic [DATA_W-1:0] bound,
                                                      input logic pass);
        logic [DATA_W-1:0] mag;
        logic              sign;
        sign = 1'($urandom_range(0, 1));
        if (pass) begin
            case ($urandom_range(0, 5))
                0: mag = bound;
                1: mag = '0;
                2: mag = bound - 1;
                default: mag = $urandom_range(0, bound);
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0: mag = bound + 1;
                1: mag = 32'h7F80_0000;
                2: mag = 32'h7FC0_0000 | $urandom_range(0, 32'h003F_FFFF);
                3: mag = MAG_MASK;
                default: mag = $urandom_range(bound + 1, MAG_MASK);
            endcase
        end
        return {sign, mag[DATA_W-2:0]};
    endfunction

    function automatic logic [DATA_W-1:0] record_checksum(input record_t rec);
        logic [DATA_W-1:0] acc;
        acc = CHK_SEED;
        for (int i = 0; i < RECORD_LEN - 1; i++) acc = acc * CHK_MULT + rec[i];
        return acc;
    endfunction

    task automatic clear_record;
        rec_pos       = POS_MAGIC;
        rec_sum       = CHK_SEED;
        rec_erased    = 1'b1;
        rec_lead_zero = 1'b0;
        rec_fault     = 1'b0;
    endtask

    task automatic predict_word(input logic [DATA_W-1:0] w, input logic f);
        logic [POS_W-1:0] pos;
        status_t          st;
        if (f) clear_record();
        pos = (rec_pos > POS_LAST) ? POS_MAGIC : rec_pos;
        if (w != ERASED_WORD) rec_erased = 1'b0;
        if (pos == POS_MAGIC) begin
            rec_lead_zero = (w == '0);
            if (w != cfg_magic) rec_fault = 1'b1;
        end else if (pos == POS_VERSION) begin
            if (w != cfg_version) rec_fault = 1'b1;
        end else if ((w & MAG_MASK) > field_limit(pos)) begin
            rec_fault = 1'b1;
        end
        if (pos < POS_LAST) begin
            rec_sum = rec_sum * CHK_MULT + w;
            rec_pos = pos + 1'b1;
        end else begin
            if (rec_erased || rec_lead_zero) st = ST_NOT_CAL;
            else if (rec_fault || w != rec_sum) st = ST_INVALID;
            else st = ST_VALID;
            expected_status.push_back(st);
            clear_record();
        end
    endtask

    task automatic send_word(input logic [DATA_W-1:0] w, input logic f);
        if (tx_gap_max > 0) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_word  <= w;
        s_first <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(w, f);
        words_sent++;
    endtask

    task automatic wait_idle;
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_MAGIC) cfg_magic = value;
        else cfg_version = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_check(input reg_idx_t idx, input logic [DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            $error("prdata (%s): expected %h, actual %h", idx.name(), want, prdata);
            reg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] magic, input logic [DATA_W-1:0] version);
        apb_write(REG_MAGIC, magic);
        apb_write(REG_VERSION, version);
        apb_check(REG_MAGIC, magic);
        apb_check(REG_VERSION, version);
        n_configs++;
    endtask

    task automatic send_record(input rec_kind_e kind);
        record_t rec;
        int      len;
        int      slot;
        logic    restart;
        len    = RECORD_LEN;
        rec[0] = cfg_magic;
        rec[1] = cfg_version;
        for (int i = 2; i < RECORD_LEN - 1; i++) rec[i] = field_value(field_limit(POS_W'(i)), 1'b1);
        case (kind)
            REC_BAD_FIELD: begin
                slot      = $urandom_range(POS_ROT_LO, POS_ACC_HI);
                rec[slot] = field_value(field_limit(POS_W'(slot)), 1'b0);
            end
            REC_BAD_MAGIC:   rec[0] = cfg_magic ^ (32'd1 << $urandom_range(0, 31));
            REC_BAD_VERSION: rec[1] = cfg_version ^ (32'd1 << $urandom_range(0, 31));
            REC_LEAD_ZERO:   rec[0] = '0;
            REC_TRUNCATED:   len = $urandom_range(1, RECORD_LEN - 1);
            default: ;
        endcase
        rec[RECORD_LEN-1] = record_checksum(rec);
        if (kind == REC_BAD_SUM) rec[RECORD_LEN-1] ^= 32'd1 << $urandom_range(0, 31);
        if (kind == REC_ERASED) rec = '1;
        // restart explicitly when a partial record is still open, and at random otherwise
        restart = (rec_pos != POS_MAGIC) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) send_word(rec[i], (i == 0) && restart);
    endtask

    task automatic test_register_access;
        apb_check(REG_MAGIC, MAGIC_RESET);
        apb_check(REG_VERSION, VERSION_RESET);
        set_config(32'hC0DE_CAFE, VERSION_RESET);
    endtask

    task automatic test_valid_record;
        record_t rec;
        rec[0]  = cfg_magic;
        rec[1]  = 32'd2;
        rec[2]  = LIM_ROT;
        rec[3]  = LIM_ROT | ~MAG_MASK;
        rec[4]  = '0;
        rec[5]  = LIM_GYRO;
        rec[6]  = LIM_GYRO | ~MAG_MASK;
        rec[7]  = ~MAG_MASK;
        rec[8]  = LIM_ACCEL;
        rec[9]  = LIM_ACCEL | ~MAG_MASK;
        rec[10] = LIM_ACCEL - 1;
        rec[11] = record_checksum(rec);
        send_word(rec[0], 1'b0);
        // change the version between word zero and word one
        wait_idle();
        apb_write(REG_VERSION, rec[1]);
        for (int i = 1; i < RECORD_LEN; i++) send_word(rec[i], 1'b0);
        wait_idle();
    endtask

    task automatic test_restart_erased;
        send_word(ERASED_WORD, 1'b0);
        send_word('0, 1'b0);
        send_word(LIM_ROT + 1, 1'b0);
        for (int i = 0; i < RECORD_LEN; i++) send_word(ERASED_WORD, i == 0);
        wait_idle();
    endtask

    task automatic test_output_hold_off;
        rx_mode    = RX_ALWAYS;
        tx_gap_max = 0;
        hold_armed = 1'b1;
        repeat (6) send_record(REC_GOOD);
        wait_idle();
    endtask

    task automatic test_random_records;
        int phase_start;
        int pick;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: set_config(32'h5EED_C0DE, VERSION_RESET);
                1: set_config(ERASED_WORD, '0);
                2: set_config(32'h0000_0001, ERASED_WORD);
                3: set_config(MAGIC_RESET, VERSION_RESET);
                4: set_config($urandom, $urandom);
                default: set_config(32'h8000_0000, MAG_MASK);
            endcase
            rx_mode     = rx_mode_e'(phase % 4);
            tx_gap_max  = (phase % 3) * 4;
            phase_start = words_sent;
            while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
                pick = $urandom_range(0, 19);
                if (pick < 10) send_record(REC_GOOD);
                else if (pick < 12) send_record(REC_BAD_FIELD);
                else if (pick == 12) send_record(REC_BAD_MAGIC);
                else if (pick == 13) send_record(REC_BAD_VERSION);
                else if (pick < 16) send_record(REC_BAD_SUM);
                else if (pick == 16) send_record(REC_LEAD_ZERO);
                else if (pick == 17) send_record(REC_ERASED);
                else if (pick == 18) send_record(REC_TRUNCATED);
                else begin
                    repeat ($urandom_range(1, 20)) send_word($urandom, $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: begin
                    m_ready    <= rx_pattern[0];
                    rx_pattern  = {rx_pattern[0], rx_pattern[15:1]};
                end
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                $error("m_status: expected none, actual %0d", m_status);
                result_errors++;
            end else begin
                want_status = expected_status.pop_front();
                if (m_status !== want_status) begin
                    $error("m_status: expected %0d, actual %0d", want_status, m_status);
                    result_errors++;
                end
                status_seen[want_status]++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_access();
        test_valid_record();
        test_restart_erased();
        test_output_hold_off();
        test_random_records();
        wait_idle();
        $display("Sent %0d words; checked %0d valid, %0d invalid, %0d not-calibrated statuses",
                 words_sent, status_seen[ST_VALID], status_seen[ST_INVALID],
                 status_seen[ST_NOT_CAL]);
        $display("Covered %0d register settings, restarts and a %0d-cycle output hold-off",
                 n_configs, HOLD_OFF_CYCLES);
        if (result_errors + reg_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
